>>> rtl/rdh_pkg.sv
package rdh_pkg;

	localparam int COORD_RAW_W = 16;
	localparam int COUNT_W     = 16;
	localparam int BINS_W      = 7;
	localparam int BIN_NUM_W   = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE = 1'b1;

	localparam logic [CFG_DATA_W-1:0] BIN_WIDTH_RST   = 16'd1;
	localparam logic [BINS_W-1:0]     BINS_IN_USE_RST = 7'd64;
	localparam logic [COUNT_W-1:0]    COUNT_MAX       = 16'hFFFF;

	typedef struct packed {
		logic signed [COORD_RAW_W-1:0] pos_x;
		logic signed [COORD_RAW_W-1:0] pos_y;
		logic signed [COORD_RAW_W-1:0] pos_z;
		logic                          final_particle;
	} in_beat_t;

	typedef struct packed {
		logic [BIN_NUM_W-1:0] bin_number;
		logic [COUNT_W-1:0]   bin_count;
		logic [COUNT_W-1:0]   dropped_count;
		logic                 last_bin;
	} out_beat_t;

	typedef struct packed {
		logic load;
		logic sq_mul;
		logic sq_acc;
		logic sqrt_step;
		logic div_step;
		logic upd_rd;
		logic upd_wr;
		logic ro_issue;
	} dp_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQRT,
		ST_DIV,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_RO
	} state_t;

endpackage

>>> rtl/rdh_ctrl.sv
module rdh_ctrl #(
	parameter int COORD_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              final_particle,
	input  logic              ro_last,
	output logic              busy,
	output rdh_pkg::dp_cmd_t  cmd
);

	localparam int CNTW    = $clog2(COORD_WIDTH + 1);
	localparam int SQ_LAST = 3;

	rdh_pkg::state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic            fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rdh_pkg::ST_IDLE;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		fin_d   = fin_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			rdh_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					fin_d    = final_particle;
					cnt_d    = '0;
					state_d  = rdh_pkg::ST_SQ;
				end
			end
			rdh_pkg::ST_SQ: begin
				cmd.sq_mul = (cnt_q < CNTW'(SQ_LAST));
				cmd.sq_acc = (cnt_q != '0);
				if (cnt_q == CNTW'(SQ_LAST)) begin
					cnt_d   = '0;
					state_d = rdh_pkg::ST_SQRT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			rdh_pkg::ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == CNTW'(COORD_WIDTH)) begin
					cnt_d   = '0;
					state_d = rdh_pkg::ST_DIV;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			rdh_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNTW'(COORD_WIDTH)) begin
					cnt_d   = '0;
					state_d = rdh_pkg::ST_UPD_RD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			rdh_pkg::ST_UPD_RD: begin
				cmd.upd_rd = 1'b1;
				state_d    = rdh_pkg::ST_UPD_WR;
			end
			rdh_pkg::ST_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d    = fin_q ? rdh_pkg::ST_RO : rdh_pkg::ST_IDLE;
			end
			rdh_pkg::ST_RO: begin
				cmd.ro_issue = 1'b1;
				if (ro_last) begin
					state_d = rdh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rdh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/rdh_dp.sv
module rdh_dp #(
	parameter int NUM_BINS    = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rdh_pkg::in_beat_t                  item,
	input  rdh_pkg::dp_cmd_t                   cmd,
	input  logic [rdh_pkg::CFG_DATA_W-1:0]     wdiv,
	input  logic [rdh_pkg::BINS_W-1:0]         nb,
	output logic                               ro_last,
	output logic                               strobe,
	output rdh_pkg::out_beat_t                 result
);

	localparam int MW   = COORD_WIDTH;
	localparam int SUMW = 2 * MW + 2;
	localparam int RW   = MW + 1;
	localparam int REMW = RW + 1;
	localparam int BW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CMPW = (RW > rdh_pkg::BINS_W) ? RW : rdh_pkg::BINS_W;
	localparam int DW   = rdh_pkg::CFG_DATA_W;
	localparam int CW   = rdh_pkg::COUNT_W;

	logic [MW-1:0]   mx_q, my_q, mz_q;
	logic [MW-1:0]   cx, cy, cz;
	logic [2*MW-1:0] prod_s1;
	logic [SUMW-1:0] acc_q;
	logic [RW-1:0]   root_q;
	logic [REMW-1:0] rem_q;
	logic [DW-1:0]   drem_q;

	logic [REMW+1:0] rem_sh, trial;
	logic [REMW-1:0] rem_nx;
	logic            sq_ge;
	logic [DW:0]     dt;
	logic            dv_ge;
	logic [DW-1:0]   drem_nx;
	logic            in_range;

	logic [CW-1:0]   mem_q [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [CW-1:0]   rd_q;
	logic            rv_q;
	logic [BW-1:0]   idx_q;
	logic            inr_q;
	logic [BW-1:0]   rd_addr;
	logic [CW-1:0]   cur, inc;
	logic [CW-1:0]   dropped_q;

	logic [rdh_pkg::BINS_W-1:0] ro_cnt_q;
	logic [rdh_pkg::BINS_W-1:0] num_s1;
	logic                       last_s1;
	logic [CW-1:0]              drop_s1;
	logic                       strobe_s1;

	function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
		mag = v[MW-1] ? MW'(~v + 1'b1) : v;
	endfunction

	assign cx = mag(MW'($unsigned(item.pos_x)));
	assign cy = mag(MW'($unsigned(item.pos_y)));
	assign cz = mag(MW'($unsigned(item.pos_z)));

	// one root digit per step
	always_comb begin
		rem_sh = {rem_q, acc_q[SUMW-1 -: 2]};
		trial  = (REMW + 2)'({root_q, 2'b01});
		sq_ge  = (rem_sh >= trial);
		rem_nx = sq_ge ? REMW'(rem_sh - trial) : REMW'(rem_sh);
	end

	// one quotient bit per step, quotient shifts into root_q
	always_comb begin
		dt      = {drem_q, root_q[RW-1]};
		dv_ge   = (dt >= {1'b0, wdiv});
		drem_nx = dv_ge ? DW'(dt - {1'b0, wdiv}) : dt[DW-1:0];
	end

	assign in_range = (CMPW'(root_q) < CMPW'(nb));
	assign rd_addr  = cmd.ro_issue ? ro_cnt_q[BW-1:0] : root_q[BW-1:0];
	assign ro_last  = (ro_cnt_q + 1'b1 == nb);
	assign cur      = rv_q ? rd_q : '0;
	assign inc      = (cur == rdh_pkg::COUNT_MAX) ? cur : cur + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mx_q <= cx;
			my_q <= cy;
			mz_q <= cz;
		end else if (cmd.sq_mul) begin
			mx_q <= my_q;
			my_q <= mz_q;
		end
		if (cmd.sq_mul) begin
			prod_s1 <= mx_q * mx_q;
		end
		if (cmd.load) begin
			acc_q <= '0;
		end else if (cmd.sq_acc) begin
			acc_q <= acc_q + SUMW'(prod_s1);
		end else if (cmd.sqrt_step) begin
			acc_q <= acc_q << 2;
		end
		if (cmd.load) begin
			root_q <= '0;
			rem_q  <= '0;
			drem_q <= '0;
		end else if (cmd.sqrt_step) begin
			rem_q  <= rem_nx;
			root_q <= {root_q[RW-2:0], sq_ge};
		end else if (cmd.div_step) begin
			drem_q <= drem_nx;
			root_q <= {root_q[RW-2:0], dv_ge};
		end
		if (cmd.upd_rd) begin
			idx_q <= root_q[BW-1:0];
			inr_q <= in_range;
		end
		if (cmd.upd_wr && inr_q) begin
			mem_q[idx_q] <= inc;
		end
		if (cmd.upd_rd || cmd.ro_issue) begin
			rd_q <= mem_q[rd_addr];
			rv_q <= vld_q[rd_addr];
		end
		if (cmd.ro_issue) begin
			num_s1  <= ro_cnt_q;
			last_s1 <= ro_last;
			drop_s1 <= dropped_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			dropped_q <= '0;
			ro_cnt_q  <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.ro_issue;
			if (cmd.upd_wr) begin
				if (inr_q) begin
					vld_q[idx_q] <= 1'b1;
				end else if (dropped_q != rdh_pkg::COUNT_MAX) begin
					dropped_q <= dropped_q + 1'b1;
				end
			end
			if (cmd.ro_issue) begin
				if (ro_last) begin
					ro_cnt_q  <= '0;
					vld_q     <= '0;
					dropped_q <= '0;
				end else begin
					ro_cnt_q <= ro_cnt_q + 1'b1;
				end
			end
		end
	end

	assign strobe               = strobe_s1;
	assign result.bin_number    = rdh_pkg::BIN_NUM_W'(num_s1);
	assign result.bin_count     = cur;
	assign result.dropped_count = drop_s1;
	assign result.last_bin      = last_s1;

endmodule

>>> rtl/radial_distance_histogram.sv
// Radial distance histogram.
// Input: one particle per beat on item, taken at a clock edge with start high
// and busy low. Each particle's radius, floor(sqrt(x^2+y^2+z^2)), is divided
// by bin_width and counted in its bin, or in the dropped counter when the bin
// is at or beyond bins_in_use. Counts saturate at 65535.
// Timing: busy is high after a start beat while the particle is worked on:
// the squares on one shared multiplier, the digit-serial square root and the
// restoring divide, then the read-modify-write of the bin store. Only then,
// with busy low again, is the next particle taken.
// A particle with final_particle set is counted, then every bin in use is
// read out one beat per cycle on result, marked by strobe, in bin order,
// with last_bin on the final beat; busy stays high until the last read is
// issued, and each beat comes in the cycle after its read. The store and
// dropped counter are then empty again.
// Results cannot be held off: each beat is valid for one cycle only.
// Configuration (cfg_we, cfg_index, cfg_data) must be written only while
// idle; the block itself does not enforce it.
// Reset clears the store and counter and sets bin_width 1, bins_in_use 64.
module radial_distance_histogram #(
	parameter int NUM_BINS    = 64,
	parameter int COORD_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  rdh_pkg::in_beat_t                   item,
	input  logic                                cfg_we,
	input  logic [rdh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rdh_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                strobe,
	output rdh_pkg::out_beat_t                  result
);

	localparam int BN = rdh_pkg::BINS_W;

	logic [rdh_pkg::CFG_DATA_W-1:0] bin_width_q;
	logic [BN-1:0]                  bins_q;
	logic [rdh_pkg::CFG_DATA_W-1:0] wdiv;
	logic [BN-1:0]                  nb;
	logic                           ro_last;
	rdh_pkg::dp_cmd_t               cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= rdh_pkg::BIN_WIDTH_RST;
			bins_q      <= rdh_pkg::BINS_IN_USE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdh_pkg::CFG_BIN_WIDTH:   bin_width_q <= cfg_data;
				rdh_pkg::CFG_BINS_IN_USE: bins_q      <= cfg_data[BN-1:0];
				default: ;
			endcase
		end
	end

	assign wdiv = (bin_width_q == '0) ? rdh_pkg::CFG_DATA_W'(1) : bin_width_q;

	always_comb begin
		if (bins_q == '0) begin
			nb = BN'(1);
		end else if (bins_q > BN'(NUM_BINS)) begin
			nb = BN'(NUM_BINS);
		end else begin
			nb = bins_q;
		end
	end

	rdh_ctrl #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.final_particle (item.final_particle),
		.ro_last        (ro_last),
		.busy           (busy),
		.cmd            (cmd)
	);

	rdh_dp #(
		.NUM_BINS    (NUM_BINS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.wdiv    (wdiv),
		.nb      (nb),
		.ro_last (ro_last),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

>>> dv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_BINS = 64;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           start     = 1'b0;
	logic                           busy;
	rdh_pkg::in_beat_t              item      = '0;
	logic                           cfg_we    = 1'b0;
	logic [rdh_pkg::CFG_IDX_W-1:0]  cfg_index = rdh_pkg::CFG_BIN_WIDTH;
	logic [rdh_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic                           strobe;
	rdh_pkg::out_beat_t             result;

	radial_distance_histogram u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.strobe   (strobe),
		.result   (result)
	);

	// shadow of the block's registers and store
	bit [rdh_pkg::CFG_DATA_W-1:0] bin_width_r   = rdh_pkg::BIN_WIDTH_RST;
	bit [rdh_pkg::BINS_W-1:0]     bins_in_use_r = rdh_pkg::BINS_IN_USE_RST;
	bit [rdh_pkg::COUNT_W-1:0]    bin_tally [N_BINS];
	bit [rdh_pkg::COUNT_W-1:0]    drop_tally;

	rdh_pkg::in_beat_t  particles_pending [$];
	rdh_pkg::out_beat_t expected_bins [$];

	int pushed   = 0;
	int accepted = 0;
	int gap      = 0;
	int errors   = 0;
	bit quiet    = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic int eff_width();
		return (bin_width_r == 0) ? 1 : int'(bin_width_r);
	endfunction

	function automatic int eff_bins();
		if (bins_in_use_r == 0)
			return 1;
		if (bins_in_use_r > N_BINS)
			return N_BINS;
		return int'(bins_in_use_r);
	endfunction

	function automatic bit [33:0] magnitude(logic signed [rdh_pkg::COORD_RAW_W-1:0] v);
		bit signed [rdh_pkg::COORD_RAW_W:0] w;
		w = v;
		if (w < 0)
			w = -w;
		return 34'(w);
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic bit [33:0] floor_root(bit [33:0] n);
		bit [33:0] r;
		bit [33:0] t;
		r = '0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (34'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	task automatic count_particle(rdh_pkg::in_beat_t p);
		bit [33:0]          r2;
		bit [33:0]          rad;
		int                 bin;
		int                 nb;
		rdh_pkg::out_beat_t e;
		r2  = magnitude(p.pos_x) * magnitude(p.pos_x)
			+ magnitude(p.pos_y) * magnitude(p.pos_y)
			+ magnitude(p.pos_z) * magnitude(p.pos_z);
		rad = floor_root(r2);
		bin = int'(rad / 34'(eff_width()));
		nb  = eff_bins();
		if (bin < nb) begin
			if (bin_tally[bin] != rdh_pkg::COUNT_MAX)
				bin_tally[bin]++;
		end else if (drop_tally != rdh_pkg::COUNT_MAX) begin
			drop_tally++;
		end
		if (p.final_particle) begin
			for (int k = 0; k < nb; k++) begin
				e.bin_number    = rdh_pkg::BIN_NUM_W'(k);
				e.bin_count     = bin_tally[k];
				e.dropped_count = drop_tally;
				e.last_bin      = (k == nb - 1);
				expected_bins.push_back(e);
			end
			foreach (bin_tally[i])
				bin_tally[i] = '0;
			drop_tally = '0;
		end
	endtask

	function automatic logic [rdh_pkg::COORD_RAW_W-1:0] coord_within(int lim);
		return rdh_pkg::COORD_RAW_W'($urandom_range(0, 2 * lim) - lim);
	endfunction

	function automatic logic [rdh_pkg::COORD_RAW_W-1:0] coord_corner();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic rdh_pkg::in_beat_t rand_particle(bit fin);
		rdh_pkg::in_beat_t p;
		int                lim;
		int                mode;
		lim  = eff_bins() * eff_width() / 2;
		if (lim < 1)
			lim = 1;
		if (lim > 32767)
			lim = 32767;
		mode = $urandom_range(0, 9);
		p.final_particle = fin;
		if (mode < 3) begin
			p.pos_x = rdh_pkg::COORD_RAW_W'($urandom);
			p.pos_y = rdh_pkg::COORD_RAW_W'($urandom);
			p.pos_z = rdh_pkg::COORD_RAW_W'($urandom);
		end else if (mode < 9) begin
			p.pos_x = coord_within(lim);
			p.pos_y = coord_within(lim);
			p.pos_z = coord_within(lim);
		end else begin
			p.pos_x = coord_corner();
			p.pos_y = coord_corner();
			p.pos_z = coord_corner();
		end
		return p;
	endfunction

	task automatic push_particle(int x, int y, int z, bit fin);
		rdh_pkg::in_beat_t p;
		p.pos_x          = rdh_pkg::COORD_RAW_W'(x);
		p.pos_y          = rdh_pkg::COORD_RAW_W'(y);
		p.pos_z          = rdh_pkg::COORD_RAW_W'(z);
		p.final_particle = fin;
		particles_pending.push_back(p);
		pushed++;
	endtask

	// well-formed sets of random particles closed by a final one, some with stray finals
	task automatic queue_sets(int n);
		int left;
		int len;
		bit noise;
		@(negedge clk);
		left = n;
		while (left > 0) begin
			len   = $urandom_range(0, 6);
			if (len > left - 1)
				len = left - 1;
			noise = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++) begin
				particles_pending.push_back(
					rand_particle(noise ? 1'($urandom_range(0, 1)) : 1'b0));
			end
			particles_pending.push_back(rand_particle(1'b1));
			pushed += len + 1;
			left   -= len + 1;
		end
	endtask

	// all beats taken, all results in, then let the datapath settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted != pushed || expected_bins.size() != 0 || busy);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_reg(logic [rdh_pkg::CFG_IDX_W-1:0] idx,
		logic [rdh_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx == rdh_pkg::CFG_BIN_WIDTH)
			bin_width_r = data;
		else
			bins_in_use_r = data[rdh_pkg::BINS_W-1:0];
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				count_particle(item);
				accepted++;
				if (!quiet && $urandom_range(0, 2) == 0)
					gap = $urandom_range(1, 19);
			end
			if (!(start && busy)) begin
				if (gap > 0) begin
					// idle cycles are counted only while the block could take a beat
					if (!busy)
						gap--;
					start <= 1'b0;
				end else if (particles_pending.size() != 0) begin
					item  <= particles_pending.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		rdh_pkg::out_beat_t e;
		if (arst_n && strobe) begin
			if (expected_bins.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: bin %0d count %0d dropped %0d last %0b",
						result.bin_number, result.bin_count, result.dropped_count,
						result.last_bin);
			end else begin
				e = expected_bins.pop_front();
				if (result.bin_number !== e.bin_number || result.bin_count !== e.bin_count
					|| result.dropped_count !== e.dropped_count
					|| result.last_bin !== e.last_bin) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: got bin %0d count %0d dropped %0d last %0b, ",
							"exp bin %0d count %0d dropped %0d last %0b"},
							result.bin_number, result.bin_count, result.dropped_count,
							result.last_bin, e.bin_number, e.bin_count, e.dropped_count,
							e.last_bin);
				end
			end
		end
	end

	initial begin
		foreach (bin_tally[i])
			bin_tally[i] = '0;
		drop_tally = '0;
		repeat (9) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		repeat (3) @(posedge clk);

		// reset settings: origin, near and far bins, full-scale corners
		@(negedge clk);
		push_particle(0, 0, 0, 1'b0);
		push_particle(1, 0, 0, 1'b0);
		push_particle(0, -1, 0, 1'b0);
		push_particle(0, 0, 63, 1'b0);
		push_particle(0, 0, -64, 1'b0);
		push_particle(-32768, -32768, -32768, 1'b0);
		push_particle(32767, 32767, 32767, 1'b0);
		push_particle(3, 4, 12, 1'b0);
		push_particle(36, -36, -36, 1'b0);
		push_particle(0, 0, 0, 1'b1);
		wait_drained();

		// zero width and zero bins behave as one
		set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'h0000);
		set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'h0000);
		@(negedge clk);
		push_particle(5, 0, 0, 1'b0);
		push_particle(-2, 2, 0, 1'b1);
		wait_drained();

		// widest bin, bins above the store size clamp
		set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'hFFFF);
		set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'h007F);
		@(negedge clk);
		push_particle(-32768, -32768, -32768, 1'b1);
		push_particle(32767, -32768, 1, 1'b1);
		wait_drained();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'd1);
					set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'd1);
				end
				1: begin
					set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'd3);
					set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'd64);
				end
				2: begin
					set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'd0);
					set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'd65);
				end
				3: begin
					set_reg(rdh_pkg::CFG_BIN_WIDTH, 16'd700);
					set_reg(rdh_pkg::CFG_BINS_IN_USE, 16'd0);
				end
				default: begin
					set_reg(rdh_pkg::CFG_BIN_WIDTH, ($urandom_range(0, 1) != 0)
						? rdh_pkg::CFG_DATA_W'($urandom)
						: rdh_pkg::CFG_DATA_W'($urandom_range(1, 2000)));
					set_reg(rdh_pkg::CFG_BINS_IN_USE,
						rdh_pkg::CFG_DATA_W'($urandom_range(0, 127)));
				end
			endcase
			quiet = (ph == 7);
			queue_sets(21);
			wait_drained();
		end

		if (errors == 0 && expected_bins.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> radial_distance_histogram.f
rtl/rdh_pkg.sv
rtl/rdh_ctrl.sv
rtl/rdh_dp.sv
rtl/radial_distance_histogram.sv
dv/tb.sv
